FILE: hw/rtl/cle_pkg.sv
package cle_pkg;

    localparam int MemBytesDefault = 65536;

    // addressing modes
    localparam logic [3:0] M_IMM  = 4'd0;
    localparam logic [3:0] M_ZP   = 4'd1;
    localparam logic [3:0] M_ZPI  = 4'd2;
    localparam logic [3:0] M_ABS  = 4'd3;
    localparam logic [3:0] M_ABSI = 4'd4;
    localparam logic [3:0] M_INDX = 4'd5;
    localparam logic [3:0] M_INDY = 4'd6;
    localparam logic [3:0] M_JSR  = 4'd7;
    localparam logic [3:0] M_BAD  = 4'd8;

    // load targets
    localparam logic [1:0] T_A = 2'd0;
    localparam logic [1:0] T_X = 2'd1;
    localparam logic [1:0] T_Y = 2'd2;

    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_EXEC  = 1'b1;

    localparam logic [15:0] PC_RESET = 16'hFFFC;
    localparam logic [7:0]  SP_RESET = 8'hFF;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    typedef struct packed {
        logic [0:0]  op;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
    } t_in;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [15:0] prog_counter;
        logic [7:0]  stack_ptr;
        logic        neg_flag;
        logic        zero_flag;
        logic [2:0]  cycles_used;
        logic        bad_opcode;
    } t_out;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] tgt;
        logic       use_y;
        logic [2:0] cyc;
        logic       bad;
    } t_dec;

    function automatic t_dec cle_decode(input logic [7:0] opc);
        t_dec d;
        d = '{mode: M_BAD, tgt: T_A, use_y: 1'b0, cyc: 3'd1, bad: 1'b1};
        case (opc)
            8'hA9: d = '{M_IMM,  T_A, 1'b0, 3'd2, 1'b0};
            8'hA2: d = '{M_IMM,  T_X, 1'b0, 3'd2, 1'b0};
            8'hA0: d = '{M_IMM,  T_Y, 1'b0, 3'd2, 1'b0};
            8'hA5: d = '{M_ZP,   T_A, 1'b0, 3'd3, 1'b0};
            8'hA6: d = '{M_ZP,   T_X, 1'b0, 3'd3, 1'b0};
            8'hA4: d = '{M_ZP,   T_Y, 1'b0, 3'd3, 1'b0};
            8'hB5: d = '{M_ZPI,  T_A, 1'b0, 3'd4, 1'b0};
            8'hB6: d = '{M_ZPI,  T_X, 1'b1, 3'd4, 1'b0};
            8'hB4: d = '{M_ZPI,  T_Y, 1'b0, 3'd4, 1'b0};
            8'hAD: d = '{M_ABS,  T_A, 1'b0, 3'd4, 1'b0};
            8'hAE: d = '{M_ABS,  T_X, 1'b0, 3'd4, 1'b0};
            8'hAC: d = '{M_ABS,  T_Y, 1'b0, 3'd4, 1'b0};
            8'hBD: d = '{M_ABSI, T_A, 1'b0, 3'd4, 1'b0};
            8'hB9: d = '{M_ABSI, T_A, 1'b1, 3'd4, 1'b0};
            8'hBE: d = '{M_ABSI, T_X, 1'b1, 3'd4, 1'b0};
            8'hBC: d = '{M_ABSI, T_Y, 1'b0, 3'd4, 1'b0};
            8'hA1: d = '{M_INDX, T_A, 1'b0, 3'd6, 1'b0};
            8'hB1: d = '{M_INDY, T_A, 1'b1, 3'd5, 1'b0};
            8'h20: d = '{M_JSR,  T_A, 1'b0, 3'd6, 1'b0};
            default: d = '{M_BAD, T_A, 1'b0, 3'd1, 1'b1};
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/cle_mem.sv
module cle_mem
    import cle_pkg::*;
#(
    parameter int MEM_BYTES = MemBytesDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output logic [7:0] o_rdata,
    output logic     o_busy
);
    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;

    // clearing sweep after reset, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MEM_BYTES - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr[AW-1:0]];
    end

    assign o_busy = r_busy;
endmodule

FILE: hw/rtl/cle_core.sv
module cle_core
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_mem_busy,
    input  logic [7:0] i_mem_rdata,
    output t_mem_req   o_mem_req
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_OPC  = 4'd1;
    localparam logic [3:0] ST_OP1  = 4'd2;
    localparam logic [3:0] ST_OP2  = 4'd3;
    localparam logic [3:0] ST_PLO  = 4'd4;
    localparam logic [3:0] ST_PHI  = 4'd5;
    localparam logic [3:0] ST_LOAD = 4'd6;
    localparam logic [3:0] ST_JSR2 = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]  r_state;
    logic [15:0] r_pc;
    logic [7:0]  r_sp, r_a, r_x, r_y, r_lo, r_hi, r_ptr;
    logic        r_n, r_z, r_bad, r_oval;
    logic [3:0]  r_mode;
    logic [1:0]  r_tgt;
    logic        r_use_y;
    logic [2:0]  r_cyc;
    t_out        r_out;

    t_dec        dec;
    logic [7:0]  idx;
    logic [8:0]  lo_sum;
    logic [15:0] eff;
    logic        accept;
    logic        load_now;
    logic [7:0]  load_val;

    assign dec    = cle_decode(i_mem_rdata);
    assign idx    = r_use_y ? r_y : r_x;
    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !i_mem_busy;

    // effective address; the index is added only for absolute indexed and (zp),Y
    always_comb begin
        logic [7:0] add;
        add = 8'h00;
        if (r_mode == M_ABSI || r_mode == M_INDY) add = idx;
        lo_sum = {1'b0, r_lo} + {1'b0, add};
        eff    = {i_mem_rdata, r_lo} + {8'h00, add};
    end

    always_comb begin
        o_mem_req = '{we: 1'b0, addr: r_pc, wdata: i_mem_rdata};
        load_now  = 1'b0;
        load_val  = i_mem_rdata;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.op == OP_WRITE) begin
                    o_mem_req = '{we: 1'b1, addr: i_in.mem_addr, wdata: i_in.mem_data};
                end
            end
            ST_OPC:  o_mem_req.addr = r_pc + 16'd1;
            ST_OP1: begin
                case (r_mode)
                    M_IMM:   load_now = 1'b1;
                    M_ZP:    o_mem_req.addr = {8'h00, i_mem_rdata};
                    M_ZPI:   o_mem_req.addr = {8'h00, i_mem_rdata + idx};
                    M_INDX:  o_mem_req.addr = {8'h00, i_mem_rdata + r_x};
                    M_INDY:  o_mem_req.addr = {8'h00, i_mem_rdata};
                    default: o_mem_req.addr = r_pc + 16'd1;
                endcase
            end
            ST_OP2: begin
                if (r_mode == M_JSR) begin
                    o_mem_req = '{we: 1'b1, addr: {STACK_PAGE, r_sp}, wdata: r_pc[15:8]};
                end else begin
                    o_mem_req.addr = eff;
                end
            end
            // JSR pushes the low byte of its return address, the last operand byte
            ST_JSR2: o_mem_req = '{we: 1'b1, addr: {STACK_PAGE, r_sp}, wdata: r_pc[7:0]};
            ST_PLO:  o_mem_req.addr = {8'h00, r_ptr + 8'd1};
            ST_PHI:  o_mem_req.addr = eff;
            ST_LOAD: load_now = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= PC_RESET;
            r_sp    <= SP_RESET;
            r_a     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_n     <= 1'b0;
            r_z     <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (r_state == ST_DONE && (!r_oval || i_out_ready)) r_oval <= 1'b1;
            else if (r_oval && i_out_ready) r_oval <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cyc <= 3'd0;
                        r_bad <= 1'b0;
                        r_state <= (i_in.op == OP_WRITE) ? ST_DONE : ST_OPC;
                    end
                end
                ST_OPC: begin
                    r_pc    <= r_pc + 16'd1;
                    r_mode  <= dec.mode;
                    r_tgt   <= dec.tgt;
                    r_use_y <= dec.use_y;
                    r_cyc   <= dec.cyc;
                    r_bad   <= dec.bad;
                    r_state <= dec.bad ? ST_DONE : ST_OP1;
                end
                ST_OP1: begin
                    r_pc  <= r_pc + 16'd1;
                    r_lo  <= i_mem_rdata;
                    r_ptr <= (r_mode == M_INDX) ? i_mem_rdata + r_x : i_mem_rdata;
                    case (r_mode)
                        M_IMM:               r_state <= ST_DONE;
                        M_ZP, M_ZPI:         r_state <= ST_LOAD;
                        M_INDX, M_INDY:      r_state <= ST_PLO;
                        default:             r_state <= ST_OP2;
                    endcase
                end
                ST_OP2: begin
                    r_hi <= i_mem_rdata;
                    if (r_mode == M_JSR) begin
                        r_sp    <= r_sp - 8'd1;
                        r_state <= ST_JSR2;
                    end else begin
                        r_pc <= r_pc + 16'd1;
                        if (lo_sum[8]) r_cyc <= r_cyc + 3'd1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_JSR2: begin
                    r_sp    <= r_sp - 8'd1;
                    r_pc    <= {r_hi, r_lo};
                    r_state <= ST_DONE;
                end
                ST_PLO: begin
                    r_lo    <= i_mem_rdata;
                    r_state <= ST_PHI;
                end
                ST_PHI: begin
                    if (r_mode == M_INDY && lo_sum[8]) r_cyc <= r_cyc + 3'd1;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: r_state <= ST_DONE;
                ST_DONE: begin
                    // publish once the output slot is free
                    if (!r_oval || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (load_now) begin
                case (r_tgt)
                    T_A:     r_a <= load_val;
                    T_X:     r_x <= load_val;
                    T_Y:     r_y <= load_val;
                    default: r_a <= load_val;
                endcase
                r_n <= load_val[7];
                r_z <= (load_val == 8'h00);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_oval || i_out_ready)) begin
            r_out <= '{acc: r_a, index_x: r_x, index_y: r_y, prog_counter: r_pc,
                       stack_ptr: r_sp, neg_flag: r_n, zero_flag: r_z,
                       cycles_used: r_cyc, bad_opcode: r_bad};
        end
    end

    assign o_out_valid = r_oval;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("request taken while an instruction is in flight");
    a_bad_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.bad_opcode) |-> (o_out.cycles_used == 3'd1))
        else $error("unknown opcode with wrong cycle count");
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_state == ST_IDLE || r_state == ST_OP2 || r_state == ST_JSR2))
        else $error("memory write from an unexpected state");
`endif
endmodule

FILE: hw/rtl/cpu_load_and_call_executor.sv
// Executes LDA/LDX/LDY in all standard addressing modes and JSR absolute
// against a byte memory, or writes one memory byte, one request at a time.
// After reset the memory is swept to zero at one byte a cycle, so no
// request is taken until the sweep is done. An instruction steps through
// one dependent access at a time on the single-port synchronous memory:
// opcode, operands, pointer bytes, then the data byte or the two stack
// pushes. A finished result waits in the output register while the next
// request is taken. MEM_BYTES must be a power of two; addresses use its
// low bits.
module cpu_load_and_call_executor
    import cle_pkg::*;
#(
    parameter int MEM_BYTES = MemBytesDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;

    cle_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    cle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_mem_busy  (mem_busy),
        .i_mem_rdata (mem_rdata),
        .o_mem_req   (mem_req)
    );
endmodule

FILE: tb/sv/cpu_load_and_call_executor_tb.sv
`timescale 1ns / 100ps

module cpu_load_and_call_executor_tb;
    import cle_pkg::*;

    // opcodes exercised by the stimulus
    localparam logic [7:0] OPC_LDA_IMM  = 8'hA9;
    localparam logic [7:0] OPC_LDX_IMM  = 8'hA2;
    localparam logic [7:0] OPC_LDY_IMM  = 8'hA0;
    localparam logic [7:0] OPC_LDA_ZP   = 8'hA5;
    localparam logic [7:0] OPC_LDX_ZP   = 8'hA6;
    localparam logic [7:0] OPC_LDY_ZP   = 8'hA4;
    localparam logic [7:0] OPC_LDA_ZPX  = 8'hB5;
    localparam logic [7:0] OPC_LDX_ZPY  = 8'hB6;
    localparam logic [7:0] OPC_LDY_ZPX  = 8'hB4;
    localparam logic [7:0] OPC_LDA_ABS  = 8'hAD;
    localparam logic [7:0] OPC_LDX_ABS  = 8'hAE;
    localparam logic [7:0] OPC_LDY_ABS  = 8'hAC;
    localparam logic [7:0] OPC_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OPC_LDA_ABSY = 8'hB9;
    localparam logic [7:0] OPC_LDX_ABSY = 8'hBE;
    localparam logic [7:0] OPC_LDY_ABSX = 8'hBC;
    localparam logic [7:0] OPC_LDA_INDX = 8'hA1;
    localparam logic [7:0] OPC_LDA_INDY = 8'hB1;
    localparam logic [7:0] OPC_JSR      = 8'h20;

    localparam int MEM_SIZE = MemBytesDefault;
    localparam int MAX_GAP  = 14;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    cpu_load_and_call_executor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Shadow CPU: own copy of memory and registers, stepped per accepted
    // request to produce the expected register snapshot.
    // ---------------------------------------------------------------------
    logic [7:0]  shadow_mem [MEM_SIZE];
    logic [15:0] shadow_pc;
    logic [7:0]  shadow_sp;
    logic [7:0]  shadow_a;
    logic [7:0]  shadow_x;
    logic [7:0]  shadow_y;
    logic        shadow_n;
    logic        shadow_z;

    t_out expected_snapshots[$];
    t_in  pending_requests[$];
    int   error_count;
    bit   stim_done;
    bit   hold_sender;

    function automatic logic [7:0] shadow_rd(input logic [15:0] addr);
        return shadow_mem[addr % MEM_SIZE];
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] v;
        v = shadow_rd(shadow_pc);
        shadow_pc = shadow_pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch_byte();
        hi = fetch_byte();
        return {hi, lo};
    endfunction

    // zero-page pointer, high byte wraps within page zero
    function automatic logic [15:0] zp_vector(input logic [7:0] zp);
        logic [7:0] zp_hi;
        zp_hi = zp + 8'd1;
        return {shadow_rd({8'h00, zp_hi}), shadow_rd({8'h00, zp})};
    endfunction

    // base + index, counting the page-carry penalty
    function automatic logic [15:0] add_index(input logic [15:0] base,
                                              input logic [7:0] idx,
                                              inout logic [2:0] cyc);
        if ({1'b0, base[7:0]} + {1'b0, idx} > 9'h0FF)
            cyc = cyc + 3'd1;
        return base + {8'h00, idx};
    endfunction

    function automatic t_out execute_request(input t_in req);
        t_out       r;
        logic [7:0] opc;
        logic [7:0] zp;
        logic [7:0] val;
        logic [15:0] ea;
        logic [15:0] ret;
        logic [2:0] cyc;
        logic [1:0] tgt;
        logic       loads;
        logic       bad;
        cyc   = 3'd0;
        bad   = 1'b0;
        loads = 1'b0;
        tgt   = T_A;
        ea    = 16'd0;
        if (req.op == OP_WRITE) begin
            shadow_mem[req.mem_addr % MEM_SIZE] = req.mem_data;
        end else begin
            opc = fetch_byte();
            loads = 1'b1;
            case (opc)
                OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM: begin
                    ea = shadow_pc;
                    shadow_pc = shadow_pc + 16'd1;
                    cyc = 3'd2;
                end
                OPC_LDA_ZP, OPC_LDX_ZP, OPC_LDY_ZP: begin
                    ea = {8'h00, fetch_byte()};
                    cyc = 3'd3;
                end
                OPC_LDA_ZPX, OPC_LDY_ZPX: begin
                    zp = fetch_byte() + shadow_x;
                    ea = {8'h00, zp};
                    cyc = 3'd4;
                end
                OPC_LDX_ZPY: begin
                    zp = fetch_byte() + shadow_y;
                    ea = {8'h00, zp};
                    cyc = 3'd4;
                end
                OPC_LDA_ABS, OPC_LDX_ABS, OPC_LDY_ABS: begin
                    ea = fetch_word();
                    cyc = 3'd4;
                end
                OPC_LDA_ABSX, OPC_LDY_ABSX: begin
                    cyc = 3'd4;
                    ea = add_index(fetch_word(), shadow_x, cyc);
                end
                OPC_LDA_ABSY, OPC_LDX_ABSY: begin
                    cyc = 3'd4;
                    ea = add_index(fetch_word(), shadow_y, cyc);
                end
                OPC_LDA_INDX: begin
                    zp = fetch_byte() + shadow_x;
                    ea = zp_vector(zp);
                    cyc = 3'd6;
                end
                OPC_LDA_INDY: begin
                    cyc = 3'd5;
                    ea = add_index(zp_vector(fetch_byte()), shadow_y, cyc);
                end
                OPC_JSR: begin
                    loads = 1'b0;
                    ea = fetch_word();
                    ret = shadow_pc - 16'd1;
                    shadow_mem[{STACK_PAGE, shadow_sp} % MEM_SIZE] = ret[15:8];
                    shadow_sp = shadow_sp - 8'd1;
                    shadow_mem[{STACK_PAGE, shadow_sp} % MEM_SIZE] = ret[7:0];
                    shadow_sp = shadow_sp - 8'd1;
                    shadow_pc = ea;
                    cyc = 3'd6;
                end
                default: begin
                    loads = 1'b0;
                    bad = 1'b1;
                    cyc = 3'd1;
                end
            endcase
            if (loads) begin
                case (opc)
                    OPC_LDX_IMM, OPC_LDX_ZP, OPC_LDX_ZPY, OPC_LDX_ABS,
                    OPC_LDX_ABSY: tgt = T_X;
                    OPC_LDY_IMM, OPC_LDY_ZP, OPC_LDY_ZPX, OPC_LDY_ABS,
                    OPC_LDY_ABSX: tgt = T_Y;
                    default: tgt = T_A;
                endcase
                val = shadow_rd(ea);
                case (tgt)
                    T_X: shadow_x = val;
                    T_Y: shadow_y = val;
                    default: shadow_a = val;
                endcase
                shadow_n = val[7];
                shadow_z = (val == 8'd0);
            end
        end
        r.acc          = shadow_a;
        r.index_x      = shadow_x;
        r.index_y      = shadow_y;
        r.prog_counter = shadow_pc;
        r.stack_ptr    = shadow_sp;
        r.neg_flag     = shadow_n;
        r.zero_flag    = shadow_z;
        r.cycles_used  = cyc;
        r.bad_opcode   = bad;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------------
    function automatic t_in write_req(input logic [15:0] addr, input logic [7:0] data);
        t_in r;
        r.op = OP_WRITE;
        r.mem_addr = addr;
        r.mem_data = data;
        return r;
    endfunction

    // exec request with junk in the unused fields
    function automatic t_in exec_req();
        t_in r;
        r.op = OP_EXEC;
        r.mem_addr = 16'($urandom);
        r.mem_data = 8'($urandom);
        return r;
    endfunction

    // three bytes placed at an address, then one execute
    task automatic queue_program(input logic [15:0] at, input logic [7:0] b0,
                                 input logic [7:0] b1, input logic [7:0] b2);
        pending_requests.push_back(write_req(at, b0));
        pending_requests.push_back(write_req(at + 16'd1, b1));
        pending_requests.push_back(write_req(at + 16'd2, b2));
        pending_requests.push_back(exec_req());
    endtask

    function automatic logic [7:0] random_opcode();
        logic [7:0] table_ops [19];
        table_ops = '{OPC_LDA_IMM, OPC_LDX_IMM, OPC_LDY_IMM, OPC_LDA_ZP, OPC_LDX_ZP,
                      OPC_LDY_ZP, OPC_LDA_ZPX, OPC_LDX_ZPY, OPC_LDY_ZPX, OPC_LDA_ABS,
                      OPC_LDX_ABS, OPC_LDY_ABS, OPC_LDA_ABSX, OPC_LDA_ABSY,
                      OPC_LDX_ABSY, OPC_LDY_ABSX, OPC_LDA_INDX, OPC_LDA_INDY, OPC_JSR};
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return table_ops[$urandom_range(0, 18)];
    endfunction

    // ---------------------------------------------------------------------
    // Driver: one pending request at a time with a random hold-off before it
    // ---------------------------------------------------------------------
    int send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= $urandom_range(0, MAX_GAP);
        end else if (i_in_valid && o_in_ready) begin
            expected_snapshots.push_back(execute_request(i_in));
            if (send_gap == 0 && !hold_sender && pending_requests.size() != 0) begin
                i_in <= pending_requests.pop_front();
                send_gap <= $urandom_range(0, MAX_GAP);
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (!hold_sender && pending_requests.size() != 0) begin
                i_in       <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
                send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
            end
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back-pressure, compare against the oldest expectation
    // ---------------------------------------------------------------------
    int   stall_left;
    t_out want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, MAX_GAP);
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_snapshots.size() == 0) begin
                    $error("result with nothing expected");
                    error_count++;
                end else begin
                    want = expected_snapshots.pop_front();
                    if (o_out.acc !== want.acc) begin
                        $error("acc exp %h got %h", want.acc, o_out.acc); error_count++;
                    end
                    if (o_out.index_x !== want.index_x) begin
                        $error("index_x exp %h got %h", want.index_x, o_out.index_x);
                        error_count++;
                    end
                    if (o_out.index_y !== want.index_y) begin
                        $error("index_y exp %h got %h", want.index_y, o_out.index_y);
                        error_count++;
                    end
                    if (o_out.prog_counter !== want.prog_counter) begin
                        $error("prog_counter exp %h got %h", want.prog_counter,
                               o_out.prog_counter);
                        error_count++;
                    end
                    if (o_out.stack_ptr !== want.stack_ptr) begin
                        $error("stack_ptr exp %h got %h", want.stack_ptr, o_out.stack_ptr);
                        error_count++;
                    end
                    if (o_out.neg_flag !== want.neg_flag) begin
                        $error("neg_flag exp %b got %b", want.neg_flag, o_out.neg_flag);
                        error_count++;
                    end
                    if (o_out.zero_flag !== want.zero_flag) begin
                        $error("zero_flag exp %b got %b", want.zero_flag, o_out.zero_flag);
                        error_count++;
                    end
                    if (o_out.cycles_used !== want.cycles_used) begin
                        $error("cycles_used exp %0d got %0d", want.cycles_used,
                               o_out.cycles_used);
                        error_count++;
                    end
                    if (o_out.bad_opcode !== want.bad_opcode) begin
                        $error("bad_opcode exp %b got %b", want.bad_opcode, o_out.bad_opcode);
                        error_count++;
                    end
                end
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Reset, stimulus, end of run
    // ---------------------------------------------------------------------
    initial begin
        logic [15:0] at;
        logic [15:0] prog_pc;
        logic [7:0]  opc;
        logic [7:0]  b1;
        logic [7:0]  b2;
        t_dec        dec;
        for (int k = 0; k < MEM_SIZE; k++) shadow_mem[k] = 8'h00;
        shadow_pc = PC_RESET;
        shadow_sp = SP_RESET;
        shadow_a = 8'h00;
        shadow_x = 8'h00;
        shadow_y = 8'h00;
        shadow_n = 1'b0;
        shadow_z = 1'b0;
        error_count = 0;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_in = '0;

        // directed: reset vector area, unknown opcode on cleared memory
        pending_requests.push_back(exec_req());
        // PC now 0xFFFD; LDA #$80 at the top of memory (operand at 0xFFFE)
        pending_requests.push_back(write_req(16'hFFFD, OPC_LDA_IMM));
        pending_requests.push_back(write_req(16'hFFFE, 8'h80));
        pending_requests.push_back(exec_req());
        // PC 0xFFFF: LDX #0 wraps PC to 0x0001
        pending_requests.push_back(write_req(16'hFFFF, OPC_LDX_IMM));
        pending_requests.push_back(exec_req());
        // JSR $0200 from 0x0001 (operand byte at 0x0000 is 0 -> LDX #0 used it)
        queue_program(16'h0001, OPC_JSR, 8'h00, 8'h02);
        // LDY #$FF; LDX zp,Y wrap; (zp,X) pointer wrap at 0xFF
        queue_program(16'h0200, OPC_LDY_IMM, 8'hFF, 8'h00);
        pending_requests.push_back(write_req(16'h00FE, 8'h5A));
        queue_program(16'h0202, OPC_LDX_ZPY, 8'hFF, 8'h00);
        pending_requests.push_back(write_req(16'h0000, 8'h34));
        queue_program(16'h0204, OPC_LDA_INDX, 8'hA5, 8'h00);
        // (zp),Y with the pointer at 0xFF/0x00
        queue_program(16'h0206, OPC_LDA_INDY, 8'hFF, 8'h00);
        // absolute,Y crossing top of memory
        queue_program(16'h0208, OPC_LDA_ABSY, 8'hF0, 8'hFF);

        // random: programs written at the running PC, then executed
        prog_pc = 16'h020B;
        while (pending_requests.size() < 470) begin
            opc = random_opcode();
            dec = cle_decode(opc);
            at = 16'($urandom);
            b1 = 8'($urandom);
            b2 = 8'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                // stray write anywhere
                pending_requests.push_back(write_req(at, 8'($urandom)));
            end else begin
                // refresh a zero page byte, then place and run one instruction
                pending_requests.push_back(write_req({8'h00, 8'($urandom)}, 8'($urandom)));
                queue_program(prog_pc, opc, b1, b2);
                case (dec.mode)
                    M_JSR:         prog_pc = {b2, b1};
                    M_BAD:         prog_pc = prog_pc + 16'd1;
                    M_ABS, M_ABSI: prog_pc = prog_pc + 16'd3;
                    default:       prog_pc = prog_pc + 16'd2;
                endcase
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // once fewer than 400 requests are pending, let everything drain completely once, then resume
        wait (pending_requests.size() < 400);
        @(posedge i_clk);
        hold_sender <= 1'b1;
        wait (!i_in_valid && expected_snapshots.size() == 0);
        @(posedge i_clk);
        hold_sender <= 1'b0;

        wait (pending_requests.size() == 0 && !i_in_valid);
        wait (expected_snapshots.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_snapshots.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // memory sweep after reset plus ~500 requests at worst-case pacing
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
